@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define DTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dtt_pkg.sv @@
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared widths, op codes and types of the deadline timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned NUM_EVENTS_DEF = 32;
  localparam int unsigned MAX_RESULTS    = 32;
  localparam int unsigned CNT_W          = $clog2(MAX_RESULTS + 1);

  localparam int unsigned OP_W    = 3;
  localparam int unsigned ID_W    = 5;
  localparam int unsigned DELAY_W = 31;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIN_W   = 16;

  localparam logic [WIN_W-1:0]  LAZY_RESET = 16'd300;
  localparam logic [TIME_W-1:0] SIGN_BIT   = 32'h8000_0000;

  localparam logic [OP_W-1:0] OP_ARM    = 3'd0;
  localparam logic [OP_W-1:0] OP_DISARM = 3'd1;
  localparam logic [OP_W-1:0] OP_EXPIRE = 3'd2;
  localparam logic [OP_W-1:0] OP_QNEXT  = 3'd3;
  localparam logic [OP_W-1:0] OP_QBUSY  = 3'd4;

  typedef struct packed {
    logic               expired;
    logic [ID_W-1:0]    expired_id;
    logic [DELAY_W-1:0] wait_ms;
    logic               infinite;
    logic               busy_res;
    logic               last;
  } res_t;

endpackage

@@ hw/rtl/deadline_timer_table.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_table
// Per-event deadline table in a one-port-read synchronous RAM, scanned one
// slot per cycle for the earliest deadline.
// Arm of an already armed slot passes through S_ARM_CHK; disarm clears the bit.
// Query next / query busy: one scan over all slots, then the result word.
// Expire: one scan per expired event plus one (none extra at the result cap),
// then S_FLUSH for the final word; one input word in flight.
// Reset clears the armed bits and loads the lazy window with 300; no RAM sweep.
// ----------------------------------------------------------------------------
module deadline_timer_table import dtt_pkg::*; #(
  parameter int unsigned NUM_EVENTS = NUM_EVENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [ID_W-1:0]    event_id_i,
  input  logic [DELAY_W-1:0] delay_ms_i,
  input  logic               cancelable_i,
  input  logic [TIME_W-1:0]  now_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               expired_o,
  output logic [ID_W-1:0]    expired_id_o,
  output logic [DELAY_W-1:0] wait_ms_o,
  output logic               infinite_o,
  output logic               busy_res_o,
  output logic               last_o
);

  localparam int unsigned IW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_EVENTS - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ARM_CHK = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_EMIT    = 3'd3;
  localparam logic [2:0] S_FLUSH   = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [WIN_W-1:0]      lazy_q;
  logic [NUM_EVENTS-1:0] armed_q, armed_d;
  logic [NUM_EVENTS-1:0] mcan_q;

  logic [OP_W-1:0]       op_q;
  logic [IW-1:0]         slot_q;
  logic [TIME_W-1:0]     key_q;
  logic [TIME_W-1:0]     now_q;

  logic [TIME_W-1:0]     dl_mem [NUM_EVENTS];
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [TIME_W-1:0]     rd_data_q;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [TIME_W-1:0]     wr_data;

  logic [IW-1:0]         idx_q, idx_d;
  logic                  iss_done_q, iss_done_d;
  logic                  rd_vld_q;
  logic [IW-1:0]         rd_idx_q;
  logic                  best_vld_q, best_vld_d;
  logic [IW-1:0]         best_idx_q, best_idx_d;
  logic [TIME_W-1:0]     best_diff_q, best_diff_d;
  logic                  busy_acc_q, busy_acc_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [IW-1:0]         pend_id_q, pend_id_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic                  out_vld_q;
  res_t                  res_q, res_d;
  logic                  out_load;
  logic                  out_free;

  logic                  in_acc;
  logic                  id_ok;
  logic [IW-1:0]         in_slot;
  logic                  mcan_we;
  logic [TIME_W-1:0]     arm_diff;
  logic [TIME_W-1:0]     arm_mag;
  logic                  arm_keep;
  logic [TIME_W-1:0]     scan_diff;
  logic                  scan_better;
  logic                  best_due;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign id_ok      = (32'(event_id_i) < NUM_EVENTS);
  assign in_slot    = IW'(event_id_i);
  assign out_free   = !out_vld_q || !out_stall_i;

  assign arm_diff = key_q - rd_data_q;
  assign arm_mag  = arm_diff[TIME_W-1] ? (TIME_W'(0) - arm_diff) : arm_diff;
  assign arm_keep = (arm_mag < {{(TIME_W-WIN_W){1'b0}}, lazy_q});

  // sign flip turns the signed difference order into an unsigned one
  assign scan_diff   = rd_data_q - now_q;
  assign scan_better = !best_vld_q || ((scan_diff ^ SIGN_BIT) < (best_diff_q ^ SIGN_BIT));
  assign best_due    = best_vld_q && ((best_diff_q == '0) || best_diff_q[TIME_W-1]);

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    idx_d       = idx_q;
    iss_done_d  = iss_done_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_diff_d = best_diff_q;
    busy_acc_d  = busy_acc_q;
    pend_vld_d  = pend_vld_q;
    pend_id_d   = pend_id_q;
    cnt_d       = cnt_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    wr_en       = 1'b0;
    wr_addr     = slot_q;
    wr_data     = key_q;
    mcan_we     = 1'b0;
    out_load    = 1'b0;
    res_d       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_i)
            OP_ARM: begin
              if (id_ok) begin
                mcan_we = 1'b1;
                if (armed_q[in_slot]) begin
                  rd_en   = 1'b1;
                  rd_addr = in_slot;
                  state_d = S_ARM_CHK;
                end else begin
                  wr_en            = 1'b1;
                  wr_addr          = in_slot;
                  wr_data          = now_ms_i + {1'b0, delay_ms_i};
                  armed_d[in_slot] = 1'b1;
                end
              end
            end
            OP_DISARM: begin
              if (id_ok) begin
                armed_d[in_slot] = 1'b0;
              end
            end
            OP_EXPIRE, OP_QNEXT, OP_QBUSY: begin
              state_d    = S_SCAN;
              idx_d      = '0;
              iss_done_d = 1'b0;
              best_vld_d = 1'b0;
              busy_acc_d = 1'b0;
              pend_vld_d = 1'b0;
              cnt_d      = '0;
            end
            default: ;
          endcase
        end
      end
      S_ARM_CHK: begin
        state_d = S_IDLE;
        wr_en   = !arm_keep;
      end
      S_SCAN: begin
        rd_en = !iss_done_q;
        if (rd_en) begin
          idx_d      = idx_q + 1'b1;
          iss_done_d = (idx_q == LAST_IDX);
        end
        if (rd_vld_q) begin
          if (armed_q[rd_idx_q] && scan_better) begin
            best_vld_d  = 1'b1;
            best_idx_d  = rd_idx_q;
            best_diff_d = scan_diff;
          end
          if (armed_q[rd_idx_q] && !mcan_q[rd_idx_q]) begin
            busy_acc_d = 1'b1;
          end
          if (rd_idx_q == LAST_IDX) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          case (op_q)
            OP_QNEXT: begin
              out_load       = 1'b1;
              res_d.infinite = !best_vld_q;
              res_d.wait_ms  = (best_vld_q && !best_diff_q[TIME_W-1]) ?
                               best_diff_q[DELAY_W-1:0] : '0;
              res_d.last     = 1'b1;
              state_d        = S_IDLE;
            end
            OP_QBUSY: begin
              out_load       = 1'b1;
              res_d.busy_res = busy_acc_q;
              res_d.last     = 1'b1;
              state_d        = S_IDLE;
            end
            default: begin
              if (best_due) begin
                // hold the newest hit back until we know whether it is the last
                armed_d[best_idx_q] = 1'b0;
                if (pend_vld_q) begin
                  out_load         = 1'b1;
                  res_d.expired    = 1'b1;
                  res_d.expired_id = ID_W'(pend_id_q);
                end
                pend_vld_d = 1'b1;
                pend_id_d  = best_idx_q;
                cnt_d      = cnt_q + 1'b1;
                if (cnt_d == CNT_W'(MAX_RESULTS)) begin
                  state_d = S_FLUSH;
                end else begin
                  state_d    = S_SCAN;
                  idx_d      = '0;
                  iss_done_d = 1'b0;
                  best_vld_d = 1'b0;
                end
              end else begin
                state_d = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load         = 1'b1;
          res_d.expired    = pend_vld_q;
          res_d.expired_id = pend_vld_q ? ID_W'(pend_id_q) : '0;
          res_d.last       = 1'b1;
          pend_vld_d       = 1'b0;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      lazy_q     <= LAZY_RESET;
      armed_q    <= '0;
      idx_q      <= '0;
      iss_done_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      busy_acc_q <= 1'b0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      armed_q    <= armed_d;
      idx_q      <= idx_d;
      iss_done_q <= iss_done_d;
      rd_vld_q   <= rd_en && (state_q == S_SCAN);
      best_vld_q <= best_vld_d;
      busy_acc_q <= busy_acc_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        lazy_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_i;
      slot_q <= in_slot;
      key_q  <= now_ms_i + {1'b0, delay_ms_i};
      now_q  <= now_ms_i;
    end
    if (mcan_we) begin
      mcan_q[in_slot] <= cancelable_i;
    end
    rd_idx_q    <= idx_q;
    best_idx_q  <= best_idx_d;
    best_diff_q <= best_diff_d;
    pend_id_q   <= pend_id_d;
    if (out_load) begin
      res_q <= res_d;
    end
  end

  // deadline RAM, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dl_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= dl_mem[rd_addr];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign expired_o    = res_q.expired;
  assign expired_id_o = res_q.expired_id;
  assign wait_ms_o    = res_q.wait_ms;
  assign infinite_o   = res_q.infinite;
  assign busy_res_o   = res_q.busy_res;
  assign last_o       = res_q.last;

endmodule

@@ hw/rtl/dtt_checker.sv @@
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level assertions for the deadline timer table, bound into deadline_timer_table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtt_checker import dtt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [WIN_W-1:0]   cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [OP_W-1:0]    op_i,
  input logic [ID_W-1:0]    event_id_i,
  input logic [DELAY_W-1:0] delay_ms_i,
  input logic               cancelable_i,
  input logic [TIME_W-1:0]  now_ms_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               expired_o,
  input logic [ID_W-1:0]    expired_id_o,
  input logic [DELAY_W-1:0] wait_ms_o,
  input logic               infinite_o,
  input logic               busy_res_o,
  input logic               last_o
);

  `DTT_ASSERT_SAME(a_expired_clean, out_valid_o && expired_o,
                   !infinite_o && !busy_res_o && (wait_ms_o == '0),
                   "expired word carries query fields")

  `DTT_ASSERT_SAME(a_single_is_last, out_valid_o && !expired_o, last_o,
                   "non-expiry word without last")

  `DTT_ASSERT_NEXT(a_query_blocks, in_valid_i && !in_stall_o && (op_i == OP_QNEXT),
                   in_stall_o, "query did not hold off the next word")

  `DTT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(expired_id_o) && $stable(wait_ms_o) &&
                   $stable(last_o), "stalled result word changed")

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (.*);
